// File: hdl/wavetable_pm_oscillator_defines.svh
// Assertion macros shared by the oscillator RTL.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef WAVETABLE_PM_OSCILLATOR_DEFINES_SVH
`define WAVETABLE_PM_OSCILLATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WPO_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wpo: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define WPO_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wpo: next-cycle check failed");

`endif

// File: hdl/wpo_pkg.sv
// Shared types and constants for the wavetable oscillator.
// No dependencies; used by wpo_mul and wavetable_pm_oscillator.
`timescale 1ns / 1ps

package wpo_pkg;

    // Request codes of the input channel.
    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_TICK  = 2'd1;
    localparam logic [1:0] REQ_RESET = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_PHASE_INC  = 2'd0;
    localparam logic [1:0] CFG_MOD_INDEX  = 2'd1;
    localparam logic [1:0] CFG_TABLE_SEL  = 2'd2;
    localparam logic [1:0] CFG_TABLE_SIZE = 2'd3;

    localparam int MOD_INDEX_BITS = 23;
    localparam logic [MOD_INDEX_BITS-1:0] MOD_INDEX_MAX = 23'd6553600;

    localparam int TBL_IDX_BITS = 14;
    localparam logic [3:0] SIZE_LOG2_MIN   = 4'd4;
    localparam logic [3:0] SIZE_LOG2_RESET = 4'd10;

    // The multiplier operand holds the widest interpolation weight, 32 - 4 bits.
    localparam int MUL_N     = 28;
    localparam int STEP_BITS = 5;
    localparam logic [STEP_BITS-1:0] MOD_STEPS = 5'd23;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MOD,
        ST_PHASE,
        ST_ADDR,
        ST_RD0,
        ST_RD1,
        ST_INTERP,
        ST_SUM,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic                 start;
        logic [STEP_BITS-1:0] steps;
    } mul_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mul_stat_t;

endpackage

// File: hdl/wpo_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the wavetable words.
`timescale 1ns / 1ps

module wpo_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 131072
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/wpo_mul.sv
// Bit-serial signed-by-unsigned shift-add multiplier, one multiplier bit per cycle.
// Depends on wpo_pkg for the control and status structs.
`timescale 1ns / 1ps

module wpo_mul #(
    parameter int W = 25,
    parameter int N = 28
) (
    input  logic              clk,
    input  logic              rst_n,
    input  wpo_pkg::mul_ctrl_t ctrl,
    input  logic [W-1:0]      mcand,
    input  logic [N-1:0]      mplier,
    output wpo_pkg::mul_stat_t stat,
    output logic [W:0]        hi,
    output logic [N-1:0]      lo
);

    logic [W-1:0]                    mcand_reg;
    logic [W:0]                      hi_reg;
    logic [N-1:0]                    lo_reg;
    logic [wpo_pkg::STEP_BITS-1:0]   cnt_reg;
    logic                            busy_reg;
    logic                            done_reg;
    logic [W:0]                      addend;
    logic [W:0]                      sum;

    // After k steps hi holds floor(mcand * (mplier mod 2^k) / 2^k) and the
    // low product bits have been shifted into the top of lo.
    assign addend = lo_reg[0] ? {mcand_reg[W-1], mcand_reg} : (W+1)'(0);
    assign sum    = hi_reg + addend;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctrl.start)
            begin
                cnt_reg  <= ctrl.steps;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == wpo_pkg::STEP_BITS'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            mcand_reg <= mcand;
            hi_reg    <= '0;
            lo_reg    <= mplier;
        end
        else if (busy_reg)
        begin
            hi_reg <= {sum[W], sum[W:1]};
            lo_reg <= {sum[0], lo_reg[N-1:1]};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign hi        = hi_reg;
    assign lo        = lo_reg;

endmodule

// File: hdl/wavetable_pm_oscillator.sv
// Stereo phase-modulated wavetable oscillator top level; uses wpo_pkg, wpo_mul and wpo_ram.
// Table writes and phase resets complete at their transfer. A sample tick uses the shared
// bit-serial multiplier twice per channel: 23 steps for the modulation depth and 32 - L steps
// for the interpolation weight, L being the table size log2 (4 to 14, 10 at reset); a new
// tick is taken only after the previous result enters the output register. Reset (rst_n,
// asynchronous, active low) clears phase, registers and control state; table words are
// undefined until written.
`timescale 1ns / 1ps

module wavetable_pm_oscillator #(
    parameter int NUM_TABLES      = 8,
    parameter int MAX_TABLE_WORDS = 16384,
    parameter int SAMPLE_BITS     = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_index,
    input  logic [31:0]                   cfg_data,

    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    req_type,
    input  logic [2:0]                    table_number,
    input  logic [13:0]                   word_address,
    input  logic signed [SAMPLE_BITS-1:0] word_value,
    input  logic signed [SAMPLE_BITS-1:0] mod_left,
    input  logic signed [SAMPLE_BITS-1:0] mod_right,

    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0] out_left,
    output logic signed [SAMPLE_BITS-1:0] out_right,
    output logic                          phase_wrapped
);

    localparam int SB    = SAMPLE_BITS;
    localparam int W     = SB + 1;
    localparam int DEPTH = NUM_TABLES * MAX_TABLE_WORDS;
    localparam int AW    = $clog2(DEPTH);
    localparam int LMAX  = $clog2(MAX_TABLE_WORDS + 1) - 1;
    localparam int PW    = W + 1 + wpo_pkg::MOD_INDEX_BITS;
    localparam int SH    = SB + 15;
    localparam int MIB   = wpo_pkg::MOD_INDEX_BITS;
    localparam int TIB   = wpo_pkg::TBL_IDX_BITS;

    wpo_pkg::state_t state_reg, state_next;

    logic [31:0]      phase_inc_reg;
    logic [MIB-1:0]   mod_index_reg;
    logic [2:0]       table_select_reg;
    logic [3:0]       table_size_reg;

    logic [31:0]      acc_reg;
    logic             wrap_reg;
    logic             ch_reg;
    logic [SB-1:0]    mod_right_reg;
    logic [31:0]      pl_reg;
    logic [wpo_pkg::MUL_N-1:0] f_reg;
    logic [AW-1:0]    addr1_reg;
    logic [SB-1:0]    s0_reg;
    logic [SB-1:0]    left_res_reg;
    logic [SB-1:0]    right_res_reg;
    logic [SB-1:0]    out_left_reg;
    logic [SB-1:0]    out_right_reg;
    logic             out_wrap_reg;
    logic             out_valid_reg;

    logic             in_fire;
    logic             out_load;
    logic [32:0]      acc_sum;
    logic [MIB-1:0]   mi_sat;
    logic [3:0]       l_eff;
    logic [5:0]       fb;
    logic [31:0]      frac_mask;
    logic [2:0]       sel_eff;
    logic [AW-1:0]    base;
    logic [TIB-1:0]   i0;
    logic [TIB-1:0]   i1;
    logic [TIB:0]     size_mask;
    logic [AW-1:0]    addr0;
    logic [AW-1:0]    addr1;
    logic [PW-1:0]    prod;
    logic [95:0]      prod_ext;
    logic [31:0]      mod_off;
    logic [W-1:0]     diff;
    logic [SB-1:0]    res;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [AW-1:0]    ram_raddr;
    logic [SB-1:0]    ram_rdata;

    wpo_pkg::mul_ctrl_t        mul_ctrl;
    wpo_pkg::mul_stat_t        mul_stat;
    logic [W-1:0]              mul_a;
    logic [wpo_pkg::MUL_N-1:0] mul_b;
    logic [W:0]                mul_hi;
    logic [wpo_pkg::MUL_N-1:0] mul_lo;

    assign in_ready = (state_reg == wpo_pkg::ST_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign out_load = (state_reg == wpo_pkg::ST_DONE) && (!out_valid_reg || out_ready);
    assign acc_sum  = {1'b0, acc_reg} + {1'b0, phase_inc_reg};

    assign mi_sat = (mod_index_reg > wpo_pkg::MOD_INDEX_MAX) ? wpo_pkg::MOD_INDEX_MAX
                                                            : mod_index_reg;

    // Table size is clamped between the minimum size and what the table storage can hold.
    always_comb
    begin
        if (table_size_reg < wpo_pkg::SIZE_LOG2_MIN)
        begin
            l_eff = wpo_pkg::SIZE_LOG2_MIN;
        end
        else if (table_size_reg > 4'(LMAX))
        begin
            l_eff = 4'(LMAX);
        end
        else
        begin
            l_eff = table_size_reg;
        end
    end

    assign fb        = 6'd32 - {2'b00, l_eff};
    assign frac_mask = ~(32'hFFFF_FFFF << fb);
    assign sel_eff   = ({1'b0, table_select_reg} >= 4'(NUM_TABLES)) ? 3'(NUM_TABLES - 1)
                                                                    : table_select_reg;
    assign base      = AW'(sel_eff) * AW'(MAX_TABLE_WORDS);
    assign i0        = TIB'(pl_reg >> fb);
    assign size_mask = (TIB+1)'((TIB+1)'(1) << l_eff) - (TIB+1)'(1);
    assign i1        = TIB'(((TIB+1)'(i0) + (TIB+1)'(1)) & size_mask);
    assign addr0     = base + AW'(i0);
    assign addr1     = base + AW'(i1);

    // The offset is the product of depth and sample, scaled down to a 0.32 phase;
    // bits that fall below the product get zeros from the low padding.
    assign prod     = {mul_hi, mul_lo[wpo_pkg::MUL_N-1 -: MIB]};
    assign prod_ext = {{(64-PW){prod[PW-1]}}, prod, 32'd0};
    assign mod_off  = prod_ext[SH +: 32];

    assign diff = {ram_rdata[SB-1], ram_rdata} - {s0_reg[SB-1], s0_reg};
    assign res  = s0_reg + mul_hi[SB-1:0];

    assign ram_we = in_fire && (req_type == wpo_pkg::REQ_WRITE)
                    && ({1'b0, table_number} < 4'(NUM_TABLES))
                    && ({1'b0, word_address} < 15'(MAX_TABLE_WORDS));
    assign ram_waddr = AW'(table_number) * AW'(MAX_TABLE_WORDS) + AW'(word_address);

    always_comb
    begin
        state_next     = state_reg;
        mul_ctrl.start = 1'b0;
        mul_ctrl.steps = wpo_pkg::MOD_STEPS;
        mul_a          = {mod_left[SB-1], mod_left};
        mul_b          = wpo_pkg::MUL_N'(mi_sat);
        ram_raddr      = addr1_reg;
        unique case (state_reg)
            wpo_pkg::ST_IDLE:
            begin
                if (in_fire && (req_type == wpo_pkg::REQ_TICK))
                begin
                    mul_ctrl.start = 1'b1;
                    state_next     = wpo_pkg::ST_MOD;
                end
            end
            wpo_pkg::ST_MOD:
            begin
                if (mul_stat.done)
                begin
                    state_next = wpo_pkg::ST_PHASE;
                end
            end
            wpo_pkg::ST_PHASE:
            begin
                state_next = wpo_pkg::ST_ADDR;
            end
            wpo_pkg::ST_ADDR:
            begin
                ram_raddr  = addr0;
                state_next = wpo_pkg::ST_RD0;
            end
            wpo_pkg::ST_RD0:
            begin
                state_next = wpo_pkg::ST_RD1;
            end
            wpo_pkg::ST_RD1:
            begin
                mul_ctrl.start = 1'b1;
                mul_ctrl.steps = wpo_pkg::STEP_BITS'(fb);
                mul_a          = diff;
                mul_b          = f_reg;
                state_next     = wpo_pkg::ST_INTERP;
            end
            wpo_pkg::ST_INTERP:
            begin
                if (mul_stat.done)
                begin
                    state_next = wpo_pkg::ST_SUM;
                end
            end
            wpo_pkg::ST_SUM:
            begin
                if (!ch_reg)
                begin
                    mul_ctrl.start = 1'b1;
                    mul_a          = {mod_right_reg[SB-1], mod_right_reg};
                    state_next     = wpo_pkg::ST_MOD;
                end
                else
                begin
                    state_next = wpo_pkg::ST_DONE;
                end
            end
            wpo_pkg::ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = wpo_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = wpo_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= wpo_pkg::ST_IDLE;
            phase_inc_reg    <= '0;
            mod_index_reg    <= '0;
            table_select_reg <= '0;
            table_size_reg   <= wpo_pkg::SIZE_LOG2_RESET;
            acc_reg          <= '0;
            ch_reg           <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    wpo_pkg::CFG_PHASE_INC:  phase_inc_reg    <= cfg_data;
                    wpo_pkg::CFG_MOD_INDEX:  mod_index_reg    <= cfg_data[MIB-1:0];
                    wpo_pkg::CFG_TABLE_SEL:  table_select_reg <= cfg_data[2:0];
                    wpo_pkg::CFG_TABLE_SIZE: table_size_reg   <= cfg_data[3:0];
                endcase
            end
            if (in_fire)
            begin
                case (req_type)
                    wpo_pkg::REQ_TICK:
                    begin
                        acc_reg <= acc_sum[31:0];
                        ch_reg  <= 1'b0;
                    end
                    wpo_pkg::REQ_RESET:
                    begin
                        acc_reg <= '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            if ((state_reg == wpo_pkg::ST_SUM) && !ch_reg)
            begin
                ch_reg <= 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && (req_type == wpo_pkg::REQ_TICK))
        begin
            wrap_reg      <= acc_sum[32];
            mod_right_reg <= mod_right;
        end
        if (state_reg == wpo_pkg::ST_PHASE)
        begin
            pl_reg <= acc_reg + mod_off;
        end
        if (state_reg == wpo_pkg::ST_ADDR)
        begin
            f_reg     <= wpo_pkg::MUL_N'(pl_reg & frac_mask);
            addr1_reg <= addr1;
        end
        if (state_reg == wpo_pkg::ST_RD0)
        begin
            s0_reg <= ram_rdata;
        end
        if (state_reg == wpo_pkg::ST_SUM)
        begin
            if (!ch_reg)
            begin
                left_res_reg <= res;
            end
            else
            begin
                right_res_reg <= res;
            end
        end
        if (out_load)
        begin
            out_left_reg  <= left_res_reg;
            out_right_reg <= right_res_reg;
            out_wrap_reg  <= wrap_reg;
        end
    end

    wpo_mul #(
        .W (W),
        .N (wpo_pkg::MUL_N)
    ) u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (mul_ctrl),
        .mcand  (mul_a),
        .mplier (mul_b),
        .stat   (mul_stat),
        .hi     (mul_hi),
        .lo     (mul_lo)
    );

    wpo_ram #(
        .WIDTH (SB),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (word_value),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_valid     = out_valid_reg;
    assign out_left      = out_left_reg;
    assign out_right     = out_right_reg;
    assign phase_wrapped = out_wrap_reg;

`include "wavetable_pm_oscillator_defines.svh"

    `WPO_ASSERT_IMP(a_mul_busy, (state_reg == wpo_pkg::ST_MOD || state_reg == wpo_pkg::ST_INTERP) && !mul_stat.done, mul_stat.busy)
    `WPO_ASSERT_IMP(a_done_owner, mul_stat.done, state_reg == wpo_pkg::ST_MOD || state_reg == wpo_pkg::ST_INTERP)
    `WPO_ASSERT_NXT(a_tick_starts, in_fire && req_type == wpo_pkg::REQ_TICK, state_reg == wpo_pkg::ST_MOD && mul_stat.busy)
    `WPO_ASSERT_NXT(a_out_load, out_load, out_valid_reg && state_reg == wpo_pkg::ST_IDLE)

endmodule

// File: test/tb_top.sv
// Self-checking testbench for wavetable_pm_oscillator. It keeps its own model of the phase,
// the registers and the table memory, and checks every output sample against it.
// Depends on wpo_pkg and the oscillator RTL.
`timescale 1ns / 1ps

module tb_top;

    localparam int TABLE_WORDS     = 16384;
    localparam int TOTAL_WORDS     = 8 * TABLE_WORDS;
    localparam int SETTLE_CYCLES   = 130;
    localparam int RANDOM_PHASES   = 15;
    localparam int ITEMS_PER_PHASE = 60;
    localparam int HOLD_OFF_CYCLES = 1500;
    localparam int TIMEOUT_NS      = 20_000_000;

    localparam logic [1:0]         REQ_UNUSED = 2'd3;
    localparam logic signed [23:0] SAMPLE_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] SAMPLE_MIN = 24'sh800000;

    typedef struct {
        logic [1:0]         kind;
        logic [2:0]         tbl;
        logic [13:0]        addr;
        logic signed [23:0] value;
        logic signed [23:0] mod_l;
        logic signed [23:0] mod_r;
    } osc_request_t;

    typedef struct {
        logic signed [23:0] left;
        logic signed [23:0] right;
        logic               wrapped;
    } sample_set_t;

    class sample_scoreboard;
        bit [31:0]          step_reg;
        bit [22:0]          depth_reg;
        bit [2:0]           table_reg;
        bit [3:0]           size_reg = wpo_pkg::SIZE_LOG2_RESET;
        bit [31:0]          phase_acc;
        logic signed [23:0] wave_words [TOTAL_WORDS];
        bit                 wave_written [TOTAL_WORDS];
        sample_set_t        expected_samples [$];
        int unsigned        error_count;

        function void write_register(logic [1:0] index, bit [31:0] data);
            case (index)
                wpo_pkg::CFG_PHASE_INC:  step_reg  = data;
                wpo_pkg::CFG_MOD_INDEX:  depth_reg = data[22:0];
                wpo_pkg::CFG_TABLE_SEL:  table_reg = data[2:0];
                wpo_pkg::CFG_TABLE_SIZE: size_reg  = data[3:0];
                default: ;
            endcase
        endfunction

        function int unsigned played_log2();
            int unsigned lg;
            lg = 32'(size_reg);
            if (lg < wpo_pkg::SIZE_LOG2_MIN)
                lg = 32'(wpo_pkg::SIZE_LOG2_MIN);
            if (lg > wpo_pkg::TBL_IDX_BITS)
                lg = wpo_pkg::TBL_IDX_BITS;
            return lg;
        endfunction

        // Depth (Q7.16) times sample (Q1.23) expressed in 0.32 cycles, modulo one cycle.
        function bit [31:0] mod_offset(logic signed [23:0] sample);
            longint depth;
            longint product;
            depth   = 64'((depth_reg > wpo_pkg::MOD_INDEX_MAX) ? wpo_pkg::MOD_INDEX_MAX
                                                              : depth_reg);
            product = longint'(sample) * depth;
            return 32'(product >>> 7);
        endfunction

        function logic signed [23:0] interpolate(bit [31:0] phase, int unsigned base);
            int unsigned lg;
            int unsigned frac_bits;
            int unsigned i0;
            int unsigned i1;
            longint      s0;
            longint      s1;
            longint      frac;
            longint      delta;
            lg        = played_log2();
            frac_bits = 32 - lg;
            i0        = phase >> frac_bits;
            i1        = (i0 + 1) & ((1 << lg) - 1);
            frac      = 64'(phase & ((32'd1 << frac_bits) - 32'd1));
            s0        = longint'(wave_words[base + i0]);
            s1        = longint'(wave_words[base + i1]);
            delta     = (s1 - s0) * frac;
            // The arithmetic shift floors the quotient, so falling slopes round down too.
            return 24'(s0 + (delta >>> frac_bits));
        endfunction

        function void apply_request(osc_request_t req);
            sample_set_t want;
            bit          carry;
            int unsigned base;
            case (req.kind)
                wpo_pkg::REQ_WRITE:
                begin
                    wave_words[req.tbl * TABLE_WORDS + req.addr]   = req.value;
                    wave_written[req.tbl * TABLE_WORDS + req.addr] = 1'b1;
                end
                wpo_pkg::REQ_RESET:
                    phase_acc = '0;
                wpo_pkg::REQ_TICK:
                begin
                    {carry, phase_acc} = {1'b0, phase_acc} + {1'b0, step_reg};
                    base         = table_reg * TABLE_WORDS;
                    want.left    = interpolate(phase_acc + mod_offset(req.mod_l), base);
                    want.right   = interpolate(phase_acc + mod_offset(req.mod_r), base);
                    want.wrapped = carry;
                    expected_samples = {expected_samples, want};
                end
                default: ;
            endcase
        endfunction

        function void check_samples(logic signed [23:0] left, logic signed [23:0] right,
                                    logic wrapped);
            sample_set_t want;
            if (expected_samples.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result, expected none, got left %0d right %0d wrap %0b",
                         $time, left, right, wrapped);
                return;
            end
            want = expected_samples.pop_front();
            if (left !== want.left)
            begin
                error_count++;
                $display("%0t: out_left mismatch, expected %0d, got %0d",
                         $time, want.left, left);
            end
            if (right !== want.right)
            begin
                error_count++;
                $display("%0t: out_right mismatch, expected %0d, got %0d",
                         $time, want.right, right);
            end
            if (wrapped !== want.wrapped)
            begin
                error_count++;
                $display("%0t: phase_wrapped mismatch, expected %0b, got %0b",
                         $time, want.wrapped, wrapped);
            end
        endfunction

        function int pending();
            return expected_samples.size();
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [31:0]        cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         req_type;
    logic [2:0]         table_number;
    logic [13:0]        word_address;
    logic signed [23:0] word_value;
    logic signed [23:0] mod_left;
    logic signed [23:0] mod_right;
    logic               out_valid;
    logic               out_ready;
    logic signed [23:0] out_left;
    logic signed [23:0] out_right;
    logic               phase_wrapped;

    sample_scoreboard sb;
    int               sender_quiet;
    int               receiver_quiet;
    int               hold_off_cycles;

    wavetable_pm_oscillator dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .req_type      (req_type),
        .table_number  (table_number),
        .word_address  (word_address),
        .word_value    (word_value),
        .mod_left      (mod_left),
        .mod_right     (mod_right),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_left      (out_left),
        .out_right     (out_right),
        .phase_wrapped (phase_wrapped)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #TIMEOUT_NS;
        $display("DONE: errors detected");
        $finish;
    end

    // Idle cycles before the next transfer, with occasional runs of back-to-back transfers.
    function automatic int draw_idle(inout int quiet_left);
        if (quiet_left > 0)
        begin
            quiet_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            quiet_left = $urandom_range(8, 24);
            return 0;
        end
        return $urandom_range(0, 8);
    endfunction

    function automatic logic signed [23:0] random_sample();
        case ($urandom_range(0, 9))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2: return 24'sd0;
            3: return -24'sd1;
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic osc_request_t random_request(logic [1:0] kind);
        osc_request_t req;
        req.kind  = kind;
        req.tbl   = 3'($urandom);
        req.addr  = 14'($urandom);
        req.value = 24'($urandom);
        req.mod_l = 24'($urandom);
        req.mod_r = 24'($urandom);
        return req;
    endfunction

    task automatic write_reg(logic [1:0] index, bit [31:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        sb.write_register(index, data);
        @(negedge clk);
    endtask

    task automatic set_config(bit [31:0] step, bit [31:0] depth, bit [31:0] sel,
                              bit [31:0] size);
        write_reg(wpo_pkg::CFG_PHASE_INC, step);
        write_reg(wpo_pkg::CFG_MOD_INDEX, depth);
        write_reg(wpo_pkg::CFG_TABLE_SEL, sel);
        write_reg(wpo_pkg::CFG_TABLE_SIZE, size);
        cfg_we <= 1'b0;
    endtask

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_request(osc_request_t req, bit paced);
        int gap;
        gap = paced ? draw_idle(sender_quiet) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid     <= 1'b1;
        req_type     <= req.kind;
        table_number <= req.tbl;
        word_address <= req.addr;
        word_value   <= req.value;
        mod_left     <= req.mod_l;
        mod_right    <= req.mod_r;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        sb.apply_request(req);
        @(negedge clk);
    endtask

    task automatic tick(logic signed [23:0] left, logic signed [23:0] right);
        osc_request_t req;
        req       = random_request(wpo_pkg::REQ_TICK);
        req.mod_l = left;
        req.mod_r = right;
        send_request(req, 1'b1);
    endtask

    task automatic write_word(logic [2:0] tbl, logic [13:0] addr, logic signed [23:0] value,
                              bit paced);
        osc_request_t req;
        req       = random_request(wpo_pkg::REQ_WRITE);
        req.tbl   = tbl;
        req.addr  = addr;
        req.value = value;
        send_request(req, paced);
    endtask

    task automatic simple_request(logic [1:0] kind);
        send_request(random_request(kind), 1'b1);
    endtask

    // Writes every word of the played table in the given stretch that holds no data yet.
    task automatic fill_table_range(int unsigned first, int unsigned count);
        int unsigned base;
        base = sb.table_reg * TABLE_WORDS;
        for (int unsigned a = first; a < first + count; a++)
        begin
            if (!sb.wave_written[base + a])
                write_word(sb.table_reg, 14'(a), random_sample(), 1'b0);
        end
    endtask

    // Any phase can land anywhere in the played table, so every word of it must hold data.
    task automatic fill_played_table();
        fill_table_range(0, 32'd1 << sb.played_log2());
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic run_random_phase(int phase_no);
        bit [31:0] step;
        bit [31:0] depth;
        bit [31:0] sel;
        bit [31:0] size;
        int        counted;
        int        pick;
        int        lg;
        drain();
        case ($urandom_range(0, 3))
            0: step = '0;
            1: step = '1;
            default: step = $urandom;
        endcase
        case ($urandom_range(0, 3))
            0: depth = '0;
            1: depth = 32'(wpo_pkg::MOD_INDEX_MAX);
            2: depth = $urandom_range(0, wpo_pkg::MOD_INDEX_MAX);
            default: depth = $urandom;
        endcase
        // Small tables keep the filling short.
        sel  = $urandom;
        size = ($urandom & 32'hFFFF_FFF0) | $urandom_range(0, 7);
        set_config(step, depth, sel, size);
        fill_played_table();
        if (phase_no == 1)
            hold_off_cycles = HOLD_OFF_CYCLES;
        lg      = sb.played_log2();
        counted = 0;
        while (counted < ITEMS_PER_PHASE)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                tick(random_sample(), random_sample());
            else if (pick < 85)
            begin
                if ($urandom_range(0, 3) != 0)
                    write_word(sb.table_reg, 14'($urandom_range(0, (1 << lg) - 1)),
                               random_sample(), 1'b1);
                else
                    write_word(3'($urandom), 14'($urandom), random_sample(), 1'b1);
            end
            else if (pick < 95)
                simple_request(wpo_pkg::REQ_RESET);
            else
            begin
                simple_request(REQ_UNUSED);
                continue;
            end
            counted++;
        end
    endtask

    initial
    begin
        int unsigned err_total;
        sb           = new;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        req_type     = '0;
        table_number = '0;
        word_address = '0;
        word_value   = '0;
        mod_left     = '0;
        mod_right    = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Smallest table with a size below range, full-scale step so the phase wraps.
        set_config(32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0);
        write_word(3'd0, 14'd0, SAMPLE_MAX, 1'b1);
        write_word(3'd0, 14'd1, SAMPLE_MIN, 1'b1);
        write_word(3'd0, 14'd15, -24'sd1, 1'b1);
        write_word(3'd7, 14'h3FFF, 24'sh5A5A5A, 1'b1);
        fill_played_table();
        repeat (2) tick(24'sd0, 24'sd0);
        simple_request(wpo_pkg::REQ_RESET);
        tick(24'sd0, 24'sd0);

        // Depth above its range saturates; extreme modulation samples.
        drain();
        set_config(32'h0800_0000, 32'h007F_FFFF, 32'd0, 32'd3);
        tick(SAMPLE_MAX, SAMPLE_MIN);
        tick(SAMPLE_MIN, SAMPLE_MAX);
        tick(-24'sd1, 24'sd1);
        tick(24'sd0, 24'sd0);
        simple_request(REQ_UNUSED);
        tick(SAMPLE_MAX, SAMPLE_MAX);

        // Size above range plays the largest table, on the last table number. Starting from
        // phase zero the first ticks stay low in the table, and at full depth these samples
        // move the phase by a fifth of a word at most, so only that stretch needs data.
        drain();
        set_config(32'h0123_4567, 32'(wpo_pkg::MOD_INDEX_MAX), 32'd7, 32'd15);
        simple_request(wpo_pkg::REQ_RESET);
        fill_table_range(64, 240);
        tick(SAMPLE_MAX, SAMPLE_MIN);
        tick(SAMPLE_MIN, 24'sd0);
        tick(-24'sd1, SAMPLE_MAX);
        tick(24'sd1, -24'sd1);

        for (int p = 0; p < RANDOM_PHASES; p++)
            run_random_phase(p);

        drain();
        err_total = sb.error_count;
        if (err_total == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Result side: random stalls, plus one long hold-off that backs the block up.
    initial
    begin
        int stall;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            stall = draw_idle(receiver_quiet);
            if (hold_off_cycles > 0)
            begin
                stall           = hold_off_cycles;
                hold_off_cycles = 0;
            end
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (out_valid !== 1'b1);
            sb.check_samples(out_left, out_right, phase_wrapped);
            @(negedge clk);
        end
    end

endmodule
